// File: sv/ghm_pkg.sv
// Package for the GF(2^128) GHASH multiplier: shared types and constants.
// Used by ghm_subkey, ghm_cell and gf128_ghash_multiply_top; depends on nothing.
package ghm_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W = 64;
    localparam int REG_INDEX_W = 8;

    localparam logic [REG_INDEX_W-1:0] REG_SUBKEY_HIGH = 8'd0;
    localparam logic [REG_INDEX_W-1:0] REG_SUBKEY_LOW = 8'd1;

    // Reduction by x^128 + x^7 + x^2 + x + 1 in the reflected bit order of GCM.
    localparam logic [7:0] FOLD_BYTE = 8'hE1;

    typedef logic [BLOCK_W-1:0] gf128_t;

    typedef struct packed {
        gf128_t x;
        gf128_t v;
        gf128_t acc;
    } ghm_work_t;

endpackage

// File: sv/gf128_ghash_multiply_top.sv
// Top level of the GCM GHASH multiplier: a chain of bit-slice cells times the subkey.
// Depends on ghm_pkg, ghm_subkey and ghm_cell.
//
// Usage: write the hash subkey through wr_en, wr_index and wr_data (index 0 is
// subkey bytes 0 to 7, index 1 is bytes 8 to 15; other indexes are ignored) while
// the block is idle. Present a block on block_high and block_low with in_valid;
// a beat is taken at a clock edge where in_valid is high and in_stall is low.
// The product X*H in GF(2^128) appears on product_high and product_low with
// out_valid, and is taken at an edge where out_stall is low.
// Each cell is a registered stage and folds CELL_BITS bits of the block into
// the partial product. Throughput is one beat per cycle while out_stall is low;
// the last cell is the output register.
// When the receiver stalls, the held result stays stable and the chain keeps
// taking beats until every cell is full; only then does in_stall rise.
// Reset empties all cells and clears the subkey to zero, so a product taken
// before any subkey write is zero.
module gf128_ghash_multiply_top
#(
    parameter int CELL_BITS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ghm_pkg::REG_INDEX_W-1:0] wr_index,
    input  logic [ghm_pkg::HALF_W-1:0]      wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ghm_pkg::HALF_W-1:0]      block_high,
    input  logic [ghm_pkg::HALF_W-1:0]      block_low,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ghm_pkg::HALF_W-1:0]      product_high,
    output logic [ghm_pkg::HALF_W-1:0]      product_low
);

    localparam int NUM_CELLS = ghm_pkg::BLOCK_W / CELL_BITS;

    ghm_pkg::gf128_t    subkey;
    logic               link_valid [NUM_CELLS+1];
    logic               link_ready [NUM_CELLS+1];
    ghm_pkg::ghm_work_t link_data [NUM_CELLS+1];

    ghm_subkey u_subkey
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .subkey   (subkey)
    );

    assign link_valid[0] = in_valid;
    assign link_data[0].x = {block_high, block_low};
    assign link_data[0].v = subkey;
    assign link_data[0].acc = '0;
    assign in_stall = !link_ready[0];

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        ghm_cell
        #(
            .CELL_BITS (CELL_BITS)
        )
        u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_data  (link_data[k]),
            .up_ready (link_ready[k]),
            .dn_valid (link_valid[k+1]),
            .dn_data  (link_data[k+1]),
            .dn_ready (link_ready[k+1])
        );
    end

    assign link_ready[NUM_CELLS] = !out_stall;
    assign out_valid = link_valid[NUM_CELLS];
    assign product_high = link_data[NUM_CELLS].acc[ghm_pkg::BLOCK_W-1 -: ghm_pkg::HALF_W];
    assign product_low = link_data[NUM_CELLS].acc[ghm_pkg::HALF_W-1:0];

endmodule

// File: sv/ghm_subkey.sv
// Hash subkey register pair, written through the plain configuration port.
// Depends on ghm_pkg.
module ghm_subkey
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ghm_pkg::REG_INDEX_W-1:0] wr_index,
    input  logic [ghm_pkg::HALF_W-1:0]      wr_data,
    output ghm_pkg::gf128_t                 subkey
);

    logic [ghm_pkg::HALF_W-1:0] high_reg;
    logic [ghm_pkg::HALF_W-1:0] high_next;
    logic [ghm_pkg::HALF_W-1:0] low_reg;
    logic [ghm_pkg::HALF_W-1:0] low_next;

    always_comb
    begin
        high_next = high_reg;
        low_next = low_reg;
        if (wr_en && (wr_index == ghm_pkg::REG_SUBKEY_HIGH))
        begin
            high_next = wr_data;
        end
        if (wr_en && (wr_index == ghm_pkg::REG_SUBKEY_LOW))
        begin
            low_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= '0;
            low_reg <= '0;
        end
        else
        begin
            high_reg <= high_next;
            low_reg <= low_next;
        end
    end

    assign subkey = {high_reg, low_reg};

endmodule

// File: sv/ghm_cell.sv
// One cell of the multiplier chain: handles CELL_BITS bits of the block per beat
// and hands the partial product, shifted subkey and remaining bits on. Depends on ghm_pkg.
module ghm_cell
#(
    parameter int CELL_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  ghm_pkg::ghm_work_t up_data,
    output logic               up_ready,
    output logic               dn_valid,
    output ghm_pkg::ghm_work_t dn_data,
    input  logic               dn_ready
);

    logic               valid_reg;
    logic               valid_next;
    ghm_pkg::ghm_work_t data_reg;
    ghm_pkg::ghm_work_t data_next;

    always_comb
    begin
        ghm_pkg::gf128_t acc_w;
        ghm_pkg::gf128_t v_w;
        logic            carry;
        acc_w = up_data.acc;
        v_w = up_data.v;
        for (int i = 0; i < CELL_BITS; i++)
        begin
            if (up_data.x[ghm_pkg::BLOCK_W-1-i])
            begin
                acc_w = acc_w ^ v_w;
            end
            carry = v_w[0];
            v_w = v_w >> 1;
            if (carry)
            begin
                v_w[ghm_pkg::BLOCK_W-1 -: 8] = v_w[ghm_pkg::BLOCK_W-1 -: 8] ^ ghm_pkg::FOLD_BYTE;
            end
        end
        data_next.x = up_data.x << CELL_BITS;
        data_next.v = v_w;
        data_next.acc = acc_w;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data = data_reg;

endmodule
